FILE: rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define VQD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define VQD_NEVER(label, clk, rst_n, cond) \
  `VQD_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: rtl/core/vqd_pkg.sv
package vqd_pkg;

  // defaults for the top level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF  = 24;

  // configuration port
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned SCALE_W      = 32;
  localparam int unsigned AXIS_BITS_W  = 15;
  localparam int unsigned AXIS_FIELD_W = 5;

  // result fields
  localparam int unsigned QUANT_W      = 24;
  localparam int unsigned LINK_IDX_W   = 10;
  localparam int unsigned LINK_WIDTH_W = 4;
  localparam int unsigned OUT_FIELDS_W = LINK_IDX_W + LINK_WIDTH_W + 3 * QUANT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W   = 3;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [CFG_DATA_W-1:0]  offset_x;
    logic [CFG_DATA_W-1:0]  offset_y;
    logic [CFG_DATA_W-1:0]  offset_z;
    logic [SCALE_W-1:0]     scale_x;
    logic [SCALE_W-1:0]     scale_y;
    logic [SCALE_W-1:0]     scale_z;
    logic [AXIS_BITS_W-1:0] axis_bits;
  } cfg_t;

  // search status toward the controller
  typedef struct packed {
    logic done;
    logic dup;
    logic mir;
  } srch_stat_t;

endpackage

FILE: rtl/core/vqd_store.sv
module vqd_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 72
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/vqd_search.sv
module vqd_search
  import vqd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count_i,
  input  logic [3*COORD_BITS-1:0]            vtx_i,
  output logic                               rd_en_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr_o,
  input  logic [3*COORD_BITS-1:0]            rd_data_i,
  output srch_stat_t                         stat_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     link_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CB = COORD_BITS;

  logic                 run_q, pend_q, done_q, dup_q, mir_q;
  logic [CW-1:0]        addr_q, cnt_q;
  logic [AW-1:0]        pidx_q, link_q;
  logic [CB-1:0]        vx_q, vy_q, vz_q;
  logic signed [CB:0]   negx_q;

  logic [CB-1:0]        ux, uy, uz;
  logic                 yz_eq, dup_hit, mir_hit, hit, more, issue;

  // compare the entry read last cycle against the vertex
  assign ux      = rd_data_i[CB-1:0];
  assign uy      = rd_data_i[2*CB-1:CB];
  assign uz      = rd_data_i[3*CB-1:2*CB];
  assign yz_eq   = (uy == vy_q) && (uz == vz_q);
  assign dup_hit = pend_q && yz_eq && (ux == vx_q);
  assign mir_hit = pend_q && yz_eq && ($signed({ux[CB-1], ux}) == negx_q);
  assign hit     = dup_hit || mir_hit;

  // walk the stored entries in order
  assign more      = addr_q < cnt_q;
  assign issue     = run_q && more && !hit;
  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q[AW-1:0];

  // control of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      dup_q  <= 1'b0;
      mir_q  <= 1'b0;
      addr_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      dup_q  <= 1'b0;
      mir_q  <= 1'b0;
      addr_q <= '0;
    end else if (run_q) begin
      pend_q <= issue;
      if (issue) begin
        addr_q <= addr_q + CW'(1);
      end
      if (hit) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
        dup_q  <= dup_hit;
        mir_q  <= !dup_hit;
      end else if (!pend_q && !more) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // vertex, entry count and match position
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q  <= count_i;
      vx_q   <= vtx_i[CB-1:0];
      vy_q   <= vtx_i[2*CB-1:CB];
      vz_q   <= vtx_i[3*CB-1:2*CB];
      negx_q <= -$signed({vtx_i[CB-1], vtx_i[CB-1:0]});
      link_q <= '0;
    end else begin
      if (run_q) begin
        pidx_q <= addr_q[AW-1:0];
      end
      if (run_q && hit) begin
        link_q <= pidx_q;
      end
    end
  end

  assign stat_o = '{done: done_q, dup: dup_q, mir: mir_q};
  assign link_o = link_q;

endmodule

FILE: rtl/core/vqd_quant.sv
module vqd_quant
  import vqd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [3*COORD_BITS-1:0] vtx_i,
  input  cfg_t                    cfg_i,
  output logic [QUANT_W-1:0]      q_x_o,
  output logic [QUANT_W-1:0]      q_y_o,
  output logic [QUANT_W-1:0]      q_z_o,
  output logic                    done_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = CB + 16;
  localparam int unsigned QW = CB + 17;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // largest code for a width field, width held to 1..24
  function automatic logic [QUANT_W-1:0] quant_max(input logic [AXIS_FIELD_W-1:0] field);
    logic [AXIS_FIELD_W-1:0] b;
    logic [QUANT_W:0]        one;
    b = field;
    if (b == '0) begin
      b = AXIS_FIELD_W'(1);
    end else if (b > AXIS_FIELD_W'(QUANT_W)) begin
      b = AXIS_FIELD_W'(QUANT_W);
    end
    one = (QUANT_W + 1)'(1) << b;
    return QUANT_W'(one - (QUANT_W + 1)'(1));
  endfunction

  logic                 issue_q, done_q;
  axis_e                axis_q, t1_q, t2_q;
  logic                 v1_q, v2_q;
  logic [CB-1:0]        vx_q, vy_q, vz_q;

  logic [CB-1:0]        diff_q;
  logic                 zero1_q, zero2_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [QUANT_W-1:0]   maxq1_q, maxq2_q;
  logic [PW-1:0]        p_hi_q, p_lo_q;
  logic [QUANT_W-1:0]   qx_q, qy_q, qz_q;

  logic [CB-1:0]           coord, off;
  logic [SCALE_W-1:0]      scale;
  logic [AXIS_FIELD_W-1:0] field;
  logic signed [CB:0]      diff_s;
  logic [QW-1:0]           sum;
  logic [QUANT_W-1:0]      res;

  // operands of the axis being issued
  always_comb begin
    case (axis_q)
      AXIS_X: begin
        coord = vx_q;
        off   = cfg_i.offset_x[CB-1:0];
        scale = cfg_i.scale_x;
        field = cfg_i.axis_bits[AXIS_FIELD_W-1:0];
      end
      AXIS_Y: begin
        coord = vy_q;
        off   = cfg_i.offset_y[CB-1:0];
        scale = cfg_i.scale_y;
        field = cfg_i.axis_bits[2*AXIS_FIELD_W-1:AXIS_FIELD_W];
      end
      AXIS_Z: begin
        coord = vz_q;
        off   = cfg_i.offset_z[CB-1:0];
        scale = cfg_i.scale_z;
        field = cfg_i.axis_bits[3*AXIS_FIELD_W-1:2*AXIS_FIELD_W];
      end
      default: begin
        coord = '0;
        off   = '0;
        scale = '0;
        field = '0;
      end
    endcase
  end

  // difference against the bounds minimum
  assign diff_s = $signed({coord[CB-1], coord}) - $signed({off[CB-1], off});

  // scaled value with clamp
  assign sum = QW'(p_hi_q) + QW'(p_lo_q >> 16);
  assign res = zero2_q ? '0 : ((sum > QW'(maxq2_q)) ? maxq2_q : sum[QUANT_W-1:0]);

  // axis sequencing and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      axis_q  <= AXIS_X;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      t1_q    <= AXIS_X;
      t2_q    <= AXIS_X;
      done_q  <= 1'b0;
    end else begin
      v1_q <= issue_q;
      t1_q <= axis_q;
      v2_q <= v1_q;
      t2_q <= t1_q;
      if (start_i) begin
        issue_q <= 1'b1;
        axis_q  <= AXIS_X;
        done_q  <= 1'b0;
      end else begin
        if (issue_q) begin
          case (axis_q)
            AXIS_X:  axis_q <= AXIS_Y;
            AXIS_Y:  axis_q <= AXIS_Z;
            default: issue_q <= 1'b0;
          endcase
        end
        if (v2_q && (t2_q == AXIS_Z)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vx_q <= vtx_i[CB-1:0];
      vy_q <= vtx_i[2*CB-1:CB];
      vz_q <= vtx_i[3*CB-1:2*CB];
    end
    diff_q  <= diff_s[CB-1:0];
    zero1_q <= diff_s[CB] || (diff_s == '0);
    scale_q <= scale;
    maxq1_q <= quant_max(field);
    p_hi_q  <= PW'(diff_q) * PW'(scale_q[31:16]);
    p_lo_q  <= PW'(diff_q) * PW'(scale_q[15:0]);
    zero2_q <= zero1_q;
    maxq2_q <= maxq1_q;
    if (v2_q) begin
      case (t2_q)
        AXIS_X:  qx_q <= res;
        AXIS_Y:  qy_q <= res;
        default: qz_q <= res;
      endcase
    end
  end

  assign q_x_o  = qx_q;
  assign q_y_o  = qy_q;
  assign q_z_o  = qz_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/vertex_quantize_dedup_unit.sv
// one vertex request at a time: the next is taken only once the result of the last is registered
// the scan reads one stored vertex per cycle through the single table read port, over at most
//   TABLE_DEPTH stored entries; a match ends it early
// the next input request is taken while a finished result waits in the output register
// reset (rst_ni low, asynchronous): empty table, default registers, no result pending;
//   the vertex memory itself is not cleared, the entry count keeps it empty
module vertex_quantize_dedup_unit
  import vqd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata_i,
  // vertex requests
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x, pos_y, pos_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // first_of_mesh
  input  logic                                   s_axis_tuser,
  // results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // link_index, link_width, quant_x, quant_y, quant_z, zero fill
  output logic [OUT_DATA_W-1:0]                  m_axis_tdata,
  // is_duplicate, is_mirror, table_full
  output logic [OUT_USER_W-1:0]                  m_axis_tuser
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW = 3 * COORD_BITS;

  typedef enum logic [2:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_AXIS_BITS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OUT
  } state_e;

  // bit length of (count | 1) - 1, i.e. ceil(log2(count | 1)), low four bits
  function automatic logic [LINK_WIDTH_W-1:0] link_bits(input logic [CW-1:0] cnt);
    logic [CW-1:0] m1;
    logic [5:0]    r;
    m1 = (cnt | CW'(1)) - CW'(1);
    r  = '0;
    for (int b = 0; b < CW; b++) begin
      if (m1[b]) begin
        r = 6'(b + 1);
      end
    end
    return r[LINK_WIDTH_W-1:0];
  endfunction

  cfg_t                    cfg_q;
  state_e                  state_q;
  logic                    m_valid_q;
  logic [CW-1:0]           count_q;
  logic [VW-1:0]           vtx_q;
  logic [OUT_DATA_W-1:0]   m_data_q;
  logic [OUT_USER_W-1:0]   m_user_q;

  logic                    accept, out_free, is_new, tbl_full, mem_we, quant_done;
  logic [CW-1:0]           count_start;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr, link;
  logic [VW-1:0]           rd_data;
  srch_stat_t              stat;
  logic [QUANT_W-1:0]      qx, qy, qz;
  logic [31:0]             link_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x  <= '0;
      cfg_q.offset_y  <= '0;
      cfg_q.offset_z  <= '0;
      cfg_q.scale_x   <= SCALE_W'(65536);
      cfg_q.scale_y   <= SCALE_W'(65536);
      cfg_q.scale_z   <= SCALE_W'(65536);
      cfg_q.axis_bits <= AXIS_BITS_W'(1057);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OFFSET_X:  cfg_q.offset_x  <= cfg_wdata_i;
        REG_OFFSET_Y:  cfg_q.offset_y  <= cfg_wdata_i;
        REG_OFFSET_Z:  cfg_q.offset_z  <= cfg_wdata_i;
        REG_SCALE_X:   cfg_q.scale_x   <= cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_Y:   cfg_q.scale_y   <= cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_Z:   cfg_q.scale_z   <= cfg_wdata_i[SCALE_W-1:0];
        REG_AXIS_BITS: cfg_q.axis_bits <= cfg_wdata_i[AXIS_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and table status
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign count_start   = s_axis_tuser ? '0 : count_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_new        = !stat.dup && !stat.mir;
  assign tbl_full      = count_q >= CW'(TABLE_DEPTH);
  assign mem_we        = (state_q == ST_OUT) && out_free && is_new && !tbl_full;
  assign link_ext      = 32'(link);

  vqd_store #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (vtx_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  vqd_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .count_i   (count_start),
    .vtx_i     (s_axis_tdata[VW-1:0]),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .stat_o    (stat),
    .link_o    (link)
  );

  vqd_quant #(
    .COORD_BITS (COORD_BITS)
  ) u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .vtx_i   (s_axis_tdata[VW-1:0]),
    .cfg_i   (cfg_q),
    .q_x_o   (qx),
    .q_y_o   (qy),
    .q_z_o   (qz),
    .done_o  (quant_done)
  );

  // control sequence, entry count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      count_q   <= '0;
      vtx_q     <= '0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q <= count_start;
            vtx_q   <= s_axis_tdata[VW-1:0];
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (stat.done && quant_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= {is_new && tbl_full, stat.mir, stat.dup};
            m_data_q  <= {
              (OUT_DATA_W - OUT_FIELDS_W)'(0),
              is_new ? qz : QUANT_W'(0),
              is_new ? qy : QUANT_W'(0),
              is_new ? qx : QUANT_W'(0),
              link_bits(count_q),
              link_ext[LINK_IDX_W-1:0]
            };
            if (mem_we) begin
              count_q <= count_q + CW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/core/vqd_checker.sv
`include "assert_macros.svh"

module vqd_checker
  import vqd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int unsigned Q_LSB = LINK_IDX_W + LINK_WIDTH_W;
  localparam int unsigned Q_MSB = Q_LSB + 3 * QUANT_W - 1;

  logic link_kind;
  assign link_kind = m_axis_tuser[0] || m_axis_tuser[1];

  // a pending result stays and holds its payload
  `VQD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `VQD_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // duplicate and mirror links exclude each other
  `VQD_NEVER(a_dup_mir, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

  // a link carries no quantized axes and no full flag
  `VQD_ASSERT(a_link_clean, clk_i, rst_ni, m_axis_tvalid && link_kind |-> (m_axis_tdata[Q_MSB:Q_LSB] == '0) && !m_axis_tuser[2])

  // a new vertex points at position zero
  `VQD_ASSERT(a_new_index, clk_i, rst_ni, m_axis_tvalid && !link_kind |-> (m_axis_tdata[LINK_IDX_W-1:0] == '0))

endmodule

bind vertex_quantize_dedup_unit vqd_checker u_vqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/tb_vertex_quantize_dedup_unit.sv
`timescale 1ns / 1ps

module tb_vertex_quantize_dedup_unit;
  import vqd_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned IN_DATA_W = ((3 * CB + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 64;

  // register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_AXIS_BITS
  } cfg_reg_e;

  // x in the lowest bits, same layout as the request data
  typedef struct packed {
    logic [CB-1:0] z;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } vertex_t;

  // result data as packed on the output stream
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] fill;
    logic [QUANT_W-1:0]                 qz;
    logic [QUANT_W-1:0]                 qy;
    logic [QUANT_W-1:0]                 qx;
    logic [LINK_WIDTH_W-1:0]            lw;
    logic [LINK_IDX_W-1:0]              link;
  } link_data_t;

  typedef struct {
    logic                    dup;
    logic                    mir;
    logic                    full;
    logic [LINK_IDX_W-1:0]   link;
    logic [LINK_WIDTH_W-1:0] lw;
    logic [QUANT_W-1:0]      qx;
    logic [QUANT_W-1:0]      qy;
    logic [QUANT_W-1:0]      qz;
  } vtx_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // shadow of the block: stored vertices, count and registers
  vertex_t               stored_vtx [DEPTH];
  int unsigned           stored_count = 0;
  logic [CB-1:0]         cur_off [3];
  logic [SCALE_W-1:0]    cur_scale [3];
  logic [AXIS_BITS_W-1:0] cur_widths = 15'd1057;

  vtx_result_t           awaited_results [$];
  int                    err_count = 0;
  int                    idle_pct = 27;
  bit                    hold_request = 1'b0;
  int unsigned           quiet_cycles = 0;
  int                    n_new = 0;
  int                    n_dup = 0;
  int                    n_mir = 0;
  int                    n_full = 0;

  vertex_quantize_dedup_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // pos_x, pos_y, pos_z
    .s_axis_tuser (s_axis_tuser),   // first_of_mesh
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // link_index, link_width, quant_x, quant_y, quant_z
    .m_axis_tuser (m_axis_tuser)    // is_duplicate, is_mirror, table_full
  );

  always #2 clk_i = ~clk_i;

  initial begin
    cur_off[0] = '0;
    cur_off[1] = '0;
    cur_off[2] = '0;
    cur_scale[0] = 32'h0001_0000;
    cur_scale[1] = 32'h0001_0000;
    cur_scale[2] = 32'h0001_0000;
  end

  function automatic vertex_t mk_vtx(input int x, input int y, input int z);
    vertex_t v;
    v.x = CB'(x);
    v.y = CB'(y);
    v.z = CB'(z);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_widths(input int wx, input int wy, input int wz);
    return CFG_DATA_W'({5'(wz), 5'(wy), 5'(wx)});
  endfunction

  function automatic longint abs_coord(input logic [CB-1:0] c);
    longint s;
    s = longint'($signed(c));
    return (s < 0) ? -s : s;
  endfunction

  function automatic int unsigned clog2_of(input int unsigned v);
    int unsigned b;
    b = 0;
    while (b < 32 && (64'd1 << b) < 64'(v)) b++;
    return b;
  endfunction

  // (coord - offset) * scale >> 16, saturated to the axis width
  function automatic logic [QUANT_W-1:0] quant_axis(input logic [CB-1:0] coord,
                                                   input logic [CB-1:0] off,
                                                   input logic [SCALE_W-1:0] scl,
                                                   input logic [AXIS_FIELD_W-1:0] field);
    int unsigned       bits;
    longint            cs;
    longint            os;
    longint unsigned   maxq;
    longint unsigned   diff;
    longint unsigned   q;
    cs = longint'($signed(coord));
    os = longint'($signed(off));
    bits = field;
    if (bits == 0) bits = 1;
    if (bits > 24) bits = 24;
    maxq = (64'd1 << bits) - 64'd1;
    if (cs <= os) return '0;
    diff = longint'(cs - os);
    q = (diff * 64'(scl)) >> 16;
    return (q > maxq) ? QUANT_W'(maxq) : QUANT_W'(q);
  endfunction

  // search, quantize and store one vertex in the shadow table
  function automatic vtx_result_t predict_vertex(input bit first, input vertex_t v);
    vtx_result_t r;
    int unsigned n;
    int unsigned i;
    r.dup = 1'b0;
    r.mir = 1'b0;
    r.full = 1'b0;
    r.link = '0;
    r.qx = '0;
    r.qy = '0;
    r.qz = '0;
    if (first) stored_count = 0;
    n = stored_count;
    for (i = 0; i < n; i++) begin
      if (stored_vtx[i].y == v.y && stored_vtx[i].z == v.z) begin
        if (stored_vtx[i].x == v.x) begin
          r.dup = 1'b1;
          r.link = LINK_IDX_W'(i);
          break;
        end
        if (abs_coord(stored_vtx[i].x) == abs_coord(v.x)) begin
          r.mir = 1'b1;
          r.link = LINK_IDX_W'(i);
          break;
        end
      end
    end
    r.lw = LINK_WIDTH_W'(clog2_of(n | 1));
    if (!r.dup && !r.mir) begin
      r.qx = quant_axis(v.x, cur_off[0], cur_scale[0], cur_widths[4:0]);
      r.qy = quant_axis(v.y, cur_off[1], cur_scale[1], cur_widths[9:5]);
      r.qz = quant_axis(v.z, cur_off[2], cur_scale[2], cur_widths[14:10]);
      if (n < DEPTH) begin
        stored_vtx[n] = v;
        stored_count = n + 1;
      end else begin
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  // one register write, shadow updated at once since the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_OFFSET_X: cur_off[0] = val[CB-1:0];
      REG_OFFSET_Y: cur_off[1] = val[CB-1:0];
      REG_OFFSET_Z: cur_off[2] = val[CB-1:0];
      REG_SCALE_X: cur_scale[0] = val;
      REG_SCALE_Y: cur_scale[1] = val;
      REG_SCALE_Z: cur_scale[2] = val;
      REG_AXIS_BITS: cur_widths = val[AXIS_BITS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] sz,
                              input logic [31:0] widths);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_AXIS_BITS, widths);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_offset();
    return $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 32'd1000;
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0004_0000));
      default: return 32'h0001_0000;
    endcase
  endfunction

  // full range or close around the axis offset
  function automatic logic [CB-1:0] rand_coord(input logic [CB-1:0] near);
    if ($urandom_range(0, 1)) return CB'($urandom);
    return near + CB'($urandom_range(0, 8191)) - CB'(1024);
  endfunction

  // offer one vertex request, random gaps first, predict on acceptance
  task automatic send_vertex(input bit first, input vertex_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tuser <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.insert(awaited_results.size(), predict_vertex(first, v));
  endtask

  // drop the request line and wait for every result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // duplicate, mirror and pass-over links under reset registers
  task automatic test_default_links();
    wait_idle();
    send_vertex(1'b1, mk_vtx(5, 7, 9));
    send_vertex(1'b0, mk_vtx(5, 7, 9));
    send_vertex(1'b0, mk_vtx(-5, 7, 9));
    send_vertex(1'b0, mk_vtx(6, 7, 9));
    send_vertex(1'b0, mk_vtx(-6, 7, 9));
    send_vertex(1'b0, mk_vtx(0, 0, 0));
    send_vertex(1'b0, mk_vtx(8388607, 8388607, 8388607));
    send_vertex(1'b0, mk_vtx(-8388608, -8388608, -8388608));
    send_vertex(1'b0, mk_vtx(-8388607, 8388607, 8388607));
    send_vertex(1'b1, mk_vtx(5, 7, 9));
  endtask

  // saturation, zero below offset, width clamping, ignored upper offset bits
  task automatic test_quant_limits();
    wait_idle();
    program_regs(32'hFF80_0000, 32'h0080_0000, 32'h0080_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, pack_widths(24, 24, 24));
    send_vertex(1'b1, mk_vtx(8388607, 8388607, 8388607));
    send_vertex(1'b0, mk_vtx(-8388608, -8388608, -8388608));
    send_vertex(1'b0, mk_vtx(-8388607, 0, 1));
    wait_idle();
    program_regs(32'h0100_0000, 32'h00FF_FFFF, 32'h0080_0000, 32'h0000_0000,
                 32'h0001_0000, 32'h0001_8000, pack_widths(0, 31, 25));
    send_vertex(1'b1, mk_vtx(100, 100, 100));
    send_vertex(1'b0, mk_vtx(8388607, 8388607, 8388607));
    send_vertex(1'b0, mk_vtx(-1, -1, -2));
    wait_idle();
    program_regs(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h0002_0000,
                 32'h0000_0001, 32'h7FFF_FFFF, pack_widths(1, 2, 3));
    send_vertex(1'b1, mk_vtx(8388607, 8388607, 8388607));
    send_vertex(1'b0, mk_vtx(-8388608, 8388606, 0));
  endtask

  // meshes of repeated, mirrored and near-miss vertices under random registers
  task automatic test_random_meshes(input int n_items, input bit no_gaps);
    vertex_t hist [$];
    vertex_t v;
    int      left;
    int      r;
    int      k;
    bit      first;
    wait_idle();
    program_regs(rand_offset(), rand_offset(), rand_offset(), rand_scale(), rand_scale(),
                 rand_scale(), 32'($urandom_range(0, 32767)));
    idle_pct = no_gaps ? 0 : 27;
    left = 0;
    repeat (n_items) begin
      first = 1'b0;
      if (left == 0) begin
        first = 1'b1;
        hist.delete();
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      end
      left--;
      r = $urandom_range(0, 99);
      if (hist.size() == 0 || r < 30) begin
        v.x = rand_coord(cur_off[0]);
        v.y = rand_coord(cur_off[1]);
        v.z = rand_coord(cur_off[2]);
        hist.insert(hist.size(), v);
      end else begin
        k = $urandom_range(0, hist.size() - 1);
        v = hist[k];
        if (r < 55) begin
          // exact repeat
        end else if (r < 78) begin
          v.x = -v.x;
        end else if (r < 90) begin
          v.x = rand_coord(cur_off[0]);
          hist.insert(hist.size(), v);
        end else begin
          v.z = v.z ^ (CB'(1) << $urandom_range(0, CB - 1));
          hist.insert(hist.size(), v);
        end
      end
      send_vertex(first, v);
    end
    idle_pct = 27;
  endtask

  // results held back for a long stretch while requests keep coming
  task automatic test_receiver_hold();
    wait_idle();
    hold_request = 1'b1;
    send_vertex(1'b1, mk_vtx(3, 4, 5));
    repeat (11) send_vertex(1'b0, mk_vtx($urandom, $urandom_range(0, 3), 5));
  endtask

  // result ready, with a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [QUANT_W-1:0] want,
                                      input logic [QUANT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      err_count++;
    end
  endfunction

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    vtx_result_t want;
    link_data_t  got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h user %h",
                 $realtime, m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("is_duplicate", QUANT_W'(want.dup), QUANT_W'(m_axis_tuser[0]));
        check_field("is_mirror", QUANT_W'(want.mir), QUANT_W'(m_axis_tuser[1]));
        check_field("table_full", QUANT_W'(want.full), QUANT_W'(m_axis_tuser[2]));
        check_field("link_index", QUANT_W'(want.link), QUANT_W'(got.link));
        check_field("link_width", QUANT_W'(want.lw), QUANT_W'(got.lw));
        check_field("quant_x", want.qx, got.qx);
        check_field("quant_y", want.qy, got.qy);
        check_field("quant_z", want.qz, got.qz);
        if (want.dup) n_dup++;
        else if (want.mir) n_mir++;
        else if (want.full) n_full++;
        else n_new++;
      end
    end
  end

  // stop a run that makes no progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $realtime, quiet_cycles);
        $display("tb_vertex_quantize_dedup_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_links();
    test_quant_limits();
    test_random_meshes(137, 1'b0);
    test_random_meshes(137, 1'b0);
    test_random_meshes(137, 1'b1);
    test_random_meshes(137, 1'b0);
    test_receiver_hold();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d vertices: %0d new, %0d duplicate, %0d mirror, %0d with table full",
             n_new + n_dup + n_mir + n_full, n_new, n_dup, n_mir, n_full);
    $display("random meshes over several register settings, quantizer limits, held results");
    if (err_count == 0) begin
      $display("tb_vertex_quantize_dedup_unit: clean");
    end else begin
      $display("tb_vertex_quantize_dedup_unit: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/vqd_pkg.sv
rtl/core/vqd_store.sv
rtl/core/vqd_search.sv
rtl/core/vqd_quant.sv
rtl/core/vertex_quantize_dedup_unit.sv
rtl/core/vqd_checker.sv
test/tb_vertex_quantize_dedup_unit.sv
